/* sv/ple_pkg.sv */
`timescale 1ns / 1ps

package ple_pkg;

   // largest list depth the cell command can address
   localparam int CAPACITY_DEFAULT = 16;
   localparam int CAPACITY_MAX     = 64;
   localparam int CMD_IDX_W        = $clog2(CAPACITY_MAX + 1);

   // operation codes; codes six and seven do nothing
   typedef enum logic [2:0] {
      FUNC_INS_FRONT = 3'd0,
      FUNC_INS_END   = 3'd1,
      FUNC_INS_POS   = 3'd2,
      FUNC_DEL_FRONT = 3'd3,
      FUNC_DEL_END   = 3'd4,
      FUNC_DEL_POS   = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_GATHER = 1'b1
   } state_type;

   // request beat
   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] value;
      logic [7:0]         position;
   } req_type;

   // response beat
   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] removed_value;
      logic [4:0]         entry_total;
      logic signed [31:0] first_value;
      logic signed [31:0] last_value;
   } rsp_type;

   // command broadcast along the cell row
   typedef struct packed {
      logic                 ins;
      logic                 del;
      logic [CMD_IDX_W-1:0] idx;
      logic [CMD_IDX_W-1:0] count;
      logic [31:0]          value;
   } cell_cmd_type;

endpackage

/* sv/ple_cell.sv */
`timescale 1ns / 1ps

module ple_cell #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  ple_pkg::cell_cmd_type cmd,
   input  logic [31:0]           left_data,
   input  logic [31:0]           right_data,
   output logic [31:0]           data,
   output logic [31:0]           removed_data,
   output logic [31:0]           last_data
);

   localparam int IW = ple_pkg::CMD_IDX_W;
   localparam logic [IW:0] MY_IDX = (IW + 1)'(INDEX);

   logic [31:0] data_ff;
   logic [31:0] data_in;
   logic [31:0] removed_ff;
   logic [31:0] removed_in;
   logic [IW:0] idx_ext;
   logic [IW:0] cnt_ext;

   assign idx_ext = {1'b0, cmd.idx};
   assign cnt_ext = {1'b0, cmd.count};

   // slot update: load, take from the left on insert, from the right on delete
   always_comb begin
      data_in    = data_ff;
      removed_in = '0;
      if (cmd.ins) begin
         if (MY_IDX == idx_ext) begin
            data_in = cmd.value;
         end else if ((MY_IDX > idx_ext) && (MY_IDX <= cnt_ext)) begin
            data_in = left_data;
         end
      end
      if (cmd.del) begin
         if (MY_IDX == idx_ext) begin
            removed_in = data_ff;
         end
         if ((MY_IDX >= idx_ext) && ((MY_IDX + 1'b1) < cnt_ext)) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff    <= data_in;
      removed_ff <= removed_in;
   end

   // this slot is the tail when the count reaches just past it
   assign data         = data_ff;
   assign removed_data = removed_ff;
   assign last_data    = ((MY_IDX + 1'b1) == cnt_ext) ? data_ff : '0;

endmodule

/* sv/positional_list_engine_top.sv */
`timescale 1ns / 1ps

// channel    ports                            direction  beat
// request    start, busy, req_beat            in         start high, busy low
// response   rsp_valid, rsp_beat              out        one cycle per strobe
//
// each operation has an accept cycle and a gather cycle: the accept cycle shifts the cell row in
// parallel, the next cycle gathers removed and tail values from the cells.
// busy is high for that one gather cycle; the response strobe comes the
// cycle after it, while a new request may already be taken.
// synchronous reset empties the list; slot contents are left as they were.
// the receiver cannot stall, so the response is shown for one cycle only.

module positional_list_engine_top #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ple_pkg::req_type  req_beat,
   output logic              rsp_valid,
   output ple_pkg::rsp_type  rsp_beat
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = ple_pkg::CMD_IDX_W;

   ple_pkg::state_type    state_ff;
   ple_pkg::state_type    state_in;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   ple_pkg::status_type   status_ff;
   ple_pkg::status_type   status_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   ple_pkg::rsp_type      rsp_beat_ff;
   ple_pkg::rsp_type      rsp_beat_in;
   ple_pkg::cell_cmd_type cmd;
   logic                  accept;
   logic                  is_ins;
   logic                  is_del;
   logic                  list_full;
   logic                  list_empty;
   logic [8:0]            pos_lo;
   logic [8:0]            cnt9;
   logic [8:0]            ins_pos;
   logic [8:0]            del_pos;
   logic [8:0]            slot;
   logic [31:0]           total_wide;
   logic [31:0]           removed_or;
   logic [31:0]           last_or;
   logic [31:0]           cell_data    [CAPACITY];
   logic [31:0]           cell_removed [CAPACITY];
   logic [31:0]           cell_last    [CAPACITY];

   assign busy   = (state_ff == ple_pkg::ST_GATHER);
   assign accept = start && !busy;

   assign is_ins = (req_beat.func == ple_pkg::FUNC_INS_FRONT) ||
                   (req_beat.func == ple_pkg::FUNC_INS_END)   ||
                   (req_beat.func == ple_pkg::FUNC_INS_POS);
   assign is_del = (req_beat.func == ple_pkg::FUNC_DEL_FRONT) ||
                   (req_beat.func == ple_pkg::FUNC_DEL_END)   ||
                   (req_beat.func == ple_pkg::FUNC_DEL_POS);

   assign list_full  = (count_ff == CW'(CAPACITY));
   assign list_empty = (count_ff == '0);

   // position clamping, one-based in, zero-based slot out
   assign cnt9    = 9'(count_ff);
   assign pos_lo  = (req_beat.position == 8'd0) ? 9'd1 : {1'b0, req_beat.position};
   assign ins_pos = (pos_lo > (cnt9 + 9'd1)) ? (cnt9 + 9'd1) : pos_lo;
   assign del_pos = (pos_lo > cnt9) ? cnt9 : pos_lo;

   always_comb begin
      case (req_beat.func)
         ple_pkg::FUNC_INS_FRONT: slot = 9'd0;
         ple_pkg::FUNC_INS_END:   slot = cnt9;
         ple_pkg::FUNC_INS_POS:   slot = ins_pos - 9'd1;
         ple_pkg::FUNC_DEL_FRONT: slot = 9'd0;
         ple_pkg::FUNC_DEL_END:   slot = cnt9 - 9'd1;
         ple_pkg::FUNC_DEL_POS:   slot = del_pos - 9'd1;
         default:                 slot = 9'd0;
      endcase
   end

   // command for the cell row
   always_comb begin
      cmd.ins   = accept && is_ins && !list_full;
      cmd.del   = accept && is_del && !list_empty;
      cmd.idx   = slot[IW-1:0];
      cmd.count = IW'(count_ff);
      cmd.value = req_beat.value;
   end

   // count and status of the operation
   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      if (cmd.ins) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.del) begin
         count_in = count_ff - 1'b1;
      end
      if (accept) begin
         if (is_ins && list_full) begin
            status_in = ple_pkg::STATUS_FULL;
         end else if (is_del && list_empty) begin
            status_in = ple_pkg::STATUS_EMPTY;
         end else begin
            status_in = ple_pkg::STATUS_DONE;
         end
      end
   end

   // row of list cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [31:0] left_data;
      logic [31:0] right_data;
      if (i == 0) begin : g_head
         assign left_data = '0;
      end else begin : g_body
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_data = '0;
      end else begin : g_next
         assign right_data = cell_data[i+1];
      end
      ple_cell #(
         .INDEX (i)
      ) u_cell (
         .clock        (clock),
         .cmd          (cmd),
         .left_data    (left_data),
         .right_data   (right_data),
         .data         (cell_data[i]),
         .removed_data (cell_removed[i]),
         .last_data    (cell_last[i])
      );
   end

   // gather removed and tail values, at most one cell drives each
   always_comb begin
      removed_or = '0;
      last_or    = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         removed_or = removed_or | cell_removed[i];
         last_or    = last_or | cell_last[i];
      end
   end

   assign total_wide = 32'(count_ff);

   // sequencer: next state and response
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_beat_in  = rsp_beat_ff;
      case (state_ff)
         ple_pkg::ST_IDLE: begin
            if (start) begin
               state_in = ple_pkg::ST_GATHER;
            end
         end
         ple_pkg::ST_GATHER: begin
            state_in                  = ple_pkg::ST_IDLE;
            rsp_valid_in              = 1'b1;
            rsp_beat_in.status        = status_ff;
            rsp_beat_in.removed_value = removed_or;
            rsp_beat_in.entry_total   = total_wide[4:0];
            rsp_beat_in.first_value   = list_empty ? '0 : cell_data[0];
            rsp_beat_in.last_value    = last_or;
         end
         default: begin
            state_in = ple_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ple_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ple_pkg::STATUS_DONE;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_rsp_after_gather: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ple_pkg::ST_GATHER))
      else $error("response without gather cycle");

   a_full_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (accept && is_ins && list_full) |=> (count_ff == $past(count_ff)))
      else $error("insert into full list changed count");

   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_beat.status == ple_pkg::STATUS_EMPTY)) |->
      ((rsp_beat.entry_total == 5'd0) && (rsp_beat.removed_value == '0)))
      else $error("empty status with entries or removed value");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("no gather cycle after accept");

endmodule
